FILE: rtl/font_atlas_glyph_trim_core_assert.svh
// ----------------------------------------------------------------------------
// font_atlas_glyph_trim_core_assert.svh
// assertion macros for the checker file of the glyph trim core
// ----------------------------------------------------------------------------
`ifndef FONT_ATLAS_GLYPH_TRIM_CORE_ASSERT_SVH
`define FONT_ATLAS_GLYPH_TRIM_CORE_ASSERT_SVH

// clocked assertion, held off while reset is asserted
`define FATRIM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication that must hold in the cycle after the trigger
`define FATRIM_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/fatrim_pkg.sv
// ----------------------------------------------------------------------------
// fatrim_pkg
// shared constants, types and helpers of the font atlas glyph trim core
// ----------------------------------------------------------------------------
`default_nettype none

package fatrim_pkg;

  localparam int unsigned CellSize  = 16;
  localparam int unsigned AtlasSize = 256;
  localparam int unsigned GridCells = AtlasSize / CellSize;
  localparam int unsigned CellW     = $clog2(CellSize);
  localparam int unsigned GridW     = $clog2(GridCells);
  localparam int unsigned AxisW     = $clog2(AtlasSize);
  localparam int unsigned PosW      = 2 * AxisW;
  localparam int unsigned WidthW    = 5;

  // configuration register indexes
  typedef enum logic {
    RegThreshold = 1'b0,
    RegSpaceCode = 1'b1
  } reg_e;

  typedef logic [CellSize-1:0] mask_t;

  // control shared by every cell of the ring
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  // floor(2*m/3) for a 4-bit m, by multiply with 11/32
  function automatic logic [WidthW-1:0] space_width(input logic [3:0] max_w);
    logic [9:0] prod;
    prod = 10'({max_w, 1'b0}) * 10'd11;
    return prod[9:5];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fatrim_cell.sv
// ----------------------------------------------------------------------------
// fatrim_cell
// one cell of the mask ring: holds the column ink mask of one glyph cell
// ----------------------------------------------------------------------------
`default_nettype none

module fatrim_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  fatrim_pkg::cell_ctrl_t       ctrl_i,
  input  wire                          set_i,
  input  wire [fatrim_pkg::CellW-1:0]  col_i,
  input  fatrim_pkg::mask_t            mask_i,
  output fatrim_pkg::mask_t            mask_o
);

  fatrim_pkg::mask_t mask_q, mask_d;
  fatrim_pkg::mask_t base;
  fatrim_pkg::mask_t hit;

  always_comb begin
    base = ctrl_i.clr ? '0 : mask_q;
    hit  = '0;
    if (set_i) begin
      hit[col_i] = 1'b1;
    end
    mask_o = base | hit;
    mask_d = ctrl_i.shift ? mask_i : mask_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fatrim_eval.sv
// ----------------------------------------------------------------------------
// fatrim_eval
// trim evaluator: first inked column and inked width of one cell mask
// ----------------------------------------------------------------------------
`default_nettype none

module fatrim_eval (
  input  fatrim_pkg::mask_t                mask_i,
  output logic [fatrim_pkg::CellW-1:0]     left_o,
  output logic [fatrim_pkg::WidthW-1:0]    width_o,
  output logic                             empty_o
);

  logic [fatrim_pkg::CellW-1:0] lo;
  logic [fatrim_pkg::CellW-1:0] hi;

  always_comb begin
    lo = '0;
    hi = '0;
    // lowest set bit wins, so scan downward
    for (int i = fatrim_pkg::CellSize - 1; i >= 0; i--) begin
      if (mask_i[i]) begin
        lo = fatrim_pkg::CellW'(i);
      end
    end
    for (int i = 0; i < fatrim_pkg::CellSize; i++) begin
      if (mask_i[i]) begin
        hi = fatrim_pkg::CellW'(i);
      end
    end
    empty_o = (mask_i == '0);
    if (empty_o) begin
      left_o  = '0;
      width_o = fatrim_pkg::WidthW'(fatrim_pkg::CellSize);
    end else begin
      left_o  = lo;
      width_o = fatrim_pkg::WidthW'({1'b0, hi}) - fatrim_pkg::WidthW'({1'b0, lo})
                + fatrim_pkg::WidthW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/font_atlas_glyph_trim_core.sv
// ----------------------------------------------------------------------------
// font_atlas_glyph_trim_core
// glyph trim table from a raster-order font atlas stream
// ----------------------------------------------------------------------------
// Takes a 256x256 font atlas, one pixel byte per transfer, and builds per
// 16x16 glyph cell a mask of inked columns in a ring of sixteen cells; the
// head cell collects the current glyph cell and the ring turns one step at
// every cell boundary. A pixel is taken every cycle, except that after the
// last pixel of a band of cells the input stalls while the ring unloads
// one cell per cycle through the trim evaluator into the output register
// (and at atlas end while the space entry is written); each unload step and
// the space entry also wait on the output side when it is stalled. Empty
// cells report offset 0 and width 16; the space code is skipped in its band
// and reported at atlas end with width floor(2*max/3) of the narrow widths seen.
// ----------------------------------------------------------------------------
`default_nettype none

module font_atlas_glyph_trim_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  // configuration writes
  input  wire        cfg_we_i,
  input  wire        cfg_index_i,
  input  wire [7:0]  cfg_data_i,
  // pixel stream
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire [7:0]  pixel_i,
  input  wire        restart_i,
  // trim results
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] glyph_code_o,
  output logic [3:0] left_offset_o,
  output logic [4:0] glyph_width_o,
  output logic       last_o
);

  localparam int unsigned Grid  = fatrim_pkg::GridCells;
  localparam int unsigned CellW = fatrim_pkg::CellW;
  localparam int unsigned GridW = fatrim_pkg::GridW;
  localparam int unsigned AxisW = fatrim_pkg::AxisW;
  localparam int unsigned PosW  = fatrim_pkg::PosW;
  localparam int unsigned WW    = fatrim_pkg::WidthW;

  // sequencer states
  localparam logic [1:0] StRun   = 2'd0;
  localparam logic [1:0] StDrain = 2'd1;
  localparam logic [1:0] StSpace = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [GridW-1:0] band_q, band_d;
  logic             atlas_end_q, atlas_end_d;
  logic [GridW-1:0] cnt_q, cnt_d;
  logic [3:0]       max_q, max_d;
  logic [7:0]       thr_q, space_q;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       code_q, code_d;
  logic [3:0]       left_q, left_d;
  logic [WW-1:0]    width_q, width_d;
  logic             last_q, last_d;

  // ---------------------------------------------------------------- input side
  logic             accept;
  logic [PosW-1:0]  pos_eff;
  logic [AxisW-1:0] px_x, px_y;
  logic             ink;
  logic             band_end;

  assign in_stall_o = (state_q != StRun);
  assign accept     = in_valid_i && !in_stall_o;
  // restart wipes the position before the pixel is placed
  assign pos_eff    = restart_i ? '0 : pos_q;
  assign px_x       = pos_eff[AxisW-1:0];
  assign px_y       = pos_eff[PosW-1:AxisW];
  assign ink        = (pixel_i > thr_q);
  // last pixel of the last row of a band
  assign band_end   = (px_x == '1) && (px_y[CellW-1:0] == '1);

  // ---------------------------------------------------------- output handoff
  logic out_free;
  logic drain_step;
  logic space_step;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign drain_step = (state_q == StDrain) && out_free;
  assign space_step = (state_q == StSpace) && out_free;

  // ---------------------------------------------------------------- cell ring
  fatrim_pkg::cell_ctrl_t ring_ctrl;
  fatrim_pkg::mask_t      chain [Grid];
  fatrim_pkg::mask_t      tail_in;

  assign ring_ctrl.clr   = accept && restart_i;
  // turn at each cell boundary, and once per unloaded cell
  assign ring_ctrl.shift = (accept && (px_x[CellW-1:0] == '1)) || drain_step;
  // unloaded cells come back empty for the next band
  assign tail_in = (state_q == StDrain) ? '0 : chain[0];

  for (genvar i = 0; i < Grid; i++) begin : g_cell
    fatrim_pkg::mask_t nbr;
    logic              set;
    if (i == Grid - 1) begin : g_tail
      assign nbr = tail_in;
    end else begin : g_body
      assign nbr = chain[i+1];
    end
    if (i == 0) begin : g_head
      assign set = accept && ink;
    end else begin : g_rest
      assign set = 1'b0;
    end
    fatrim_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ring_ctrl),
      .set_i  (set),
      .col_i  (px_x[CellW-1:0]),
      .mask_i (nbr),
      .mask_o (chain[i])
    );
  end

  // ------------------------------------------------------------ trim evaluate
  logic [CellW-1:0] ev_left;
  logic [WW-1:0]    ev_width;
  logic             ev_empty;

  fatrim_eval u_eval (
    .mask_i  (chain[0]),
    .left_o  (ev_left),
    .width_o (ev_width),
    .empty_o (ev_empty)
  );

  logic [7:0] drain_code;
  logic       drain_is_space;
  logic       emit_cell;
  logic       cell_last;

  assign drain_code     = {band_q, cnt_q};
  assign drain_is_space = (drain_code == space_q);
  assign emit_cell      = drain_step && !drain_is_space;
  // last of the band unless the space entry follows; a trailing space cell is skipped
  assign cell_last = !atlas_end_q &&
                     ((cnt_q == '1) ||
                      ((cnt_q == GridW'(Grid - 2)) && ({band_q, {GridW{1'b1}}} == space_q)));

  // ------------------------------------------------------------------ next state
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    band_d      = band_q;
    atlas_end_d = atlas_end_q;
    cnt_d       = cnt_q;
    max_d       = max_q;

    if (accept) begin
      pos_d = pos_eff + PosW'(1);
      if (restart_i) begin
        max_d = '0;
      end
    end

    // narrow widths feed the space estimate
    if (emit_cell && !ev_empty && !ev_width[WW-1] && (ev_width[3:0] > max_q)) begin
      max_d = ev_width[3:0];
    end
    if (space_step) begin
      max_d = '0;
    end

    unique case (state_q)
      StRun: begin
        if (accept && band_end) begin
          state_d     = StDrain;
          cnt_d       = '0;
          band_d      = px_y[AxisW-1:CellW];
          atlas_end_d = (px_y == '1);
        end
      end
      StDrain: begin
        if (drain_step) begin
          cnt_d = cnt_q + GridW'(1);
          if (cnt_q == '1) begin
            state_d = atlas_end_q ? StSpace : StRun;
          end
        end
      end
      StSpace: begin
        if (space_step) begin
          state_d = StRun;
        end
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  // ------------------------------------------------------------ output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    code_d      = code_q;
    left_d      = left_q;
    width_d     = width_q;
    last_d      = last_q;
    if (emit_cell) begin
      out_valid_d = 1'b1;
      code_d      = drain_code;
      left_d      = ev_left;
      width_d     = ev_width;
      last_d      = cell_last;
    end else if (space_step) begin
      out_valid_d = 1'b1;
      code_d      = space_q;
      left_d      = '0;
      width_d     = fatrim_pkg::space_width(max_q);
      last_d      = 1'b1;
    end
  end

  // ------------------------------------------------------------------ registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      pos_q       <= '0;
      band_q      <= '0;
      atlas_end_q <= 1'b0;
      cnt_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= 8'd0;
      space_q     <= 8'd32;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      band_q      <= band_d;
      atlas_end_q <= atlas_end_d;
      cnt_q       <= cnt_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          fatrim_pkg::RegThreshold: thr_q   <= cfg_data_i;
          fatrim_pkg::RegSpaceCode: space_q <= cfg_data_i;
          default:                  thr_q   <= thr_q;
        endcase
      end
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    left_q  <= left_d;
    width_q <= width_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign glyph_code_o  = code_q;
  assign left_offset_o = left_q;
  assign glyph_width_o = width_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

FILE: rtl/fatrim_checker.sv
// ----------------------------------------------------------------------------
// fatrim_checker
// port-level checks of the glyph trim core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "font_atlas_glyph_trim_core_assert.svh"

module fatrim_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_stall_o,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire [7:0] glyph_code_o,
  input wire [3:0] left_offset_o,
  input wire [4:0] glyph_width_o,
  input wire       last_o
);

  // a held result keeps its payload
  `FATRIM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(glyph_code_o) && $stable(left_offset_o) && $stable(glyph_width_o) && $stable(last_o), "stalled result changed")

  // the input only closes right after a pixel transfer ends a band
  `FATRIM_ASSERT(a_stall_cause, $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o), "input stalled without a band end")

  // a trimmed span never runs past the cell edge
  `FATRIM_ASSERT(a_span_fits, out_valid_o |-> ((5'({1'b0, left_offset_o}) + glyph_width_o) <= 5'd16), "trim span exceeds cell")

  // zero width only comes from the space entry, which closes its group
  `FATRIM_ASSERT(a_zero_width, (out_valid_o && (glyph_width_o == 5'd0)) |-> (last_o && (left_offset_o == 4'd0)), "zero width on a glyph result")

endmodule

bind font_atlas_glyph_trim_core fatrim_checker u_fatrim_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .glyph_code_o  (glyph_code_o),
  .left_offset_o (left_offset_o),
  .glyph_width_o (glyph_width_o),
  .last_o        (last_o)
);

`default_nettype wire
